// ----- hw/rtl/ctf_pkg.sv -----
// ctf_pkg: shared types, codes and helpers for the connection teardown fsm
// no dependencies; used by ctf_next_logic and connection_teardown_fsm
package ctf_pkg;

    // connection state, one-hot
    typedef enum logic [7:0] {
        ST_CLOSED     = 8'b0000_0001,
        ST_READY      = 8'b0000_0010,
        ST_FIN_WAIT1  = 8'b0000_0100,
        ST_FIN_WAIT2  = 8'b0000_1000,
        ST_CLOSING    = 8'b0001_0000,
        ST_TIME_WAIT  = 8'b0010_0000,
        ST_CLOSE_WAIT = 8'b0100_0000,
        ST_LAST_ACK   = 8'b1000_0000
    } t_conn_state;

    // external state codes
    localparam logic [2:0] CODE_CLOSED     = 3'd0;
    localparam logic [2:0] CODE_READY      = 3'd1;
    localparam logic [2:0] CODE_FIN_WAIT1  = 3'd2;
    localparam logic [2:0] CODE_FIN_WAIT2  = 3'd3;
    localparam logic [2:0] CODE_CLOSING    = 3'd4;
    localparam logic [2:0] CODE_TIME_WAIT  = 3'd5;
    localparam logic [2:0] CODE_CLOSE_WAIT = 3'd6;
    localparam logic [2:0] CODE_LAST_ACK   = 3'd7;

    // event opcodes
    localparam logic [1:0] OP_RECEIVE = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_TIMER   = 2'd2;

    // upper-layer notices
    localparam logic [1:0] NOTE_NONE   = 2'd0;
    localparam logic [1:0] NOTE_NEW    = 2'd1;
    localparam logic [1:0] NOTE_BROKEN = 2'd2;
    localparam logic [1:0] NOTE_CLOSED = 2'd3;

    // event flags of a received message
    typedef struct packed {
        logic reset_flag;
        logic fin_ack_flag;
        logic fin_flag;
    } t_flags;

    // one result, lowest field last
    typedef struct packed {
        logic       may_send;
        logic       bad_event;
        logic [1:0] notify;
        logic       release_res;
        logic       start_wait_timer;
        logic       send_reset;
        logic       fin_low_priority;
        logic       send_fin;
        logic       send_fin_ack;
        logic [2:0] next_state;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [2:0] state_code(t_conn_state st);
        logic [2:0] code;
        case (st)
            ST_CLOSED:     code = CODE_CLOSED;
            ST_READY:      code = CODE_READY;
            ST_FIN_WAIT1:  code = CODE_FIN_WAIT1;
            ST_FIN_WAIT2:  code = CODE_FIN_WAIT2;
            ST_CLOSING:    code = CODE_CLOSING;
            ST_TIME_WAIT:  code = CODE_TIME_WAIT;
            ST_CLOSE_WAIT: code = CODE_CLOSE_WAIT;
            ST_LAST_ACK:   code = CODE_LAST_ACK;
            default:       code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/ctf_next_logic.sv -----
// ctf_next_logic: combinational transition and action decode for one event
// depends on ctf_pkg
module ctf_next_logic (
    input  ctf_pkg::t_conn_state i_state,
    input  logic [1:0]           i_opcode,
    input  ctf_pkg::t_flags      i_flags,
    input  logic                 i_drain,
    output ctf_pkg::t_conn_state o_state,
    output ctf_pkg::t_result     o_result
);

    ctf_pkg::t_conn_state st;
    ctf_pkg::t_result     res;

    always_comb begin
        st  = i_state;
        res = '0;

        case (i_opcode)
            ctf_pkg::OP_RECEIVE: begin
                // first receive opens the connection
                if (st == ctf_pkg::ST_CLOSED) begin
                    st         = ctf_pkg::ST_READY;
                    res.notify = ctf_pkg::NOTE_NEW;
                end
                if (st == ctf_pkg::ST_TIME_WAIT) begin
                    res.send_reset = 1'b1;
                end else if (i_flags.reset_flag) begin
                    res.notify      = ctf_pkg::NOTE_BROKEN;
                    res.release_res = 1'b1;
                    st              = ctf_pkg::ST_CLOSED;
                end else if (i_flags.fin_flag) begin
                    res.send_fin_ack = 1'b1;
                    case (st)
                        ctf_pkg::ST_READY: begin
                            // passive close, own fin goes out at once
                            res.send_fin         = 1'b1;
                            res.fin_low_priority = i_drain;
                            res.notify           = ctf_pkg::NOTE_CLOSED;
                            st                   = ctf_pkg::ST_LAST_ACK;
                        end
                        ctf_pkg::ST_FIN_WAIT1: st = ctf_pkg::ST_CLOSING;
                        ctf_pkg::ST_FIN_WAIT2: begin
                            st                   = ctf_pkg::ST_TIME_WAIT;
                            res.start_wait_timer = 1'b1;
                        end
                        default: res.bad_event = 1'b1;
                    endcase
                end else if (i_flags.fin_ack_flag) begin
                    case (st)
                        ctf_pkg::ST_LAST_ACK: begin
                            st              = ctf_pkg::ST_CLOSED;
                            res.release_res = 1'b1;
                        end
                        ctf_pkg::ST_FIN_WAIT1: st = ctf_pkg::ST_FIN_WAIT2;
                        ctf_pkg::ST_CLOSING: begin
                            st                   = ctf_pkg::ST_TIME_WAIT;
                            res.start_wait_timer = 1'b1;
                        end
                        default: res.bad_event = 1'b1;
                    endcase
                end
            end
            ctf_pkg::OP_CLOSE: begin
                if (st == ctf_pkg::ST_READY || st == ctf_pkg::ST_CLOSE_WAIT) begin
                    res.send_fin         = 1'b1;
                    res.fin_low_priority = i_drain;
                    res.notify           = ctf_pkg::NOTE_CLOSED;
                    st = (st == ctf_pkg::ST_READY) ? ctf_pkg::ST_FIN_WAIT1
                                                   : ctf_pkg::ST_LAST_ACK;
                end else begin
                    res.bad_event = 1'b1;
                end
            end
            ctf_pkg::OP_TIMER: begin
                if (st == ctf_pkg::ST_TIME_WAIT) begin
                    st              = ctf_pkg::ST_CLOSED;
                    res.release_res = 1'b1;
                end else begin
                    res.bad_event = 1'b1;
                end
            end
            default: res.bad_event = 1'b1;
        endcase

        res.next_state = ctf_pkg::state_code(st);
        res.may_send   = (st == ctf_pkg::ST_CLOSED) || (st == ctf_pkg::ST_READY);
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

// ----- hw/rtl/connection_teardown_fsm.sv -----
// connection_teardown_fsm: top level of the close-handshake state machine
// depends on ctf_pkg and ctf_next_logic
//
// One event per transaction on the slave stream: tuser carries the opcode
// (receive, local close, 2msl timer expiry), tdata the flags of a received
// message. Every event yields exactly one result transaction on the master
// stream with the new state, the actions to take, the upper-layer notice,
// the error flag and the send permission. An event is captured in an input
// register, decoded by the transition logic against the state register
// and landed in the output register, so one event per clock is sustained
// while the master side takes each result. The result shows on the master
// stream from the output register until it is taken. While a result waits, the
// input register still takes one more event; after that the slave side is
// ready only in cycles in which the output register is freed. The
// drain_before_close register is written through the cfg channel, which is
// always ready; write it only while idle.
module connection_teardown_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration: bit 0 drain_before_close
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] fin_flag, [1] fin_ack_flag, [2] reset_flag, [7:3] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] next_state, [3] send_fin_ack, [4] send_fin, [5] fin_low_priority,
    // [6] send_reset, [7] start_wait_timer, [8] release_res, [10:9] notify,
    // [11] bad_event, [12] may_send, [15:13] zero
    output logic [ctf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // input stage
    logic                 r_in_valid;
    logic [1:0]           r_in_opcode;
    ctf_pkg::t_flags      r_in_flags;

    // connection state and configuration
    ctf_pkg::t_conn_state r_state;
    logic                 r_drain;

    // output stage
    logic                 r_out_valid;
    ctf_pkg::t_result     r_out;

    ctf_pkg::t_conn_state n_state;
    ctf_pkg::t_result     n_out;

    logic advance;
    logic in_take;

    // event moves from input register into output register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    ctf_next_logic u_next (
        .i_state  (r_state),
        .i_opcode (r_in_opcode),
        .i_flags  (r_in_flags),
        .i_drain  (r_drain),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ctf_pkg::ST_CLOSED;
            r_drain     <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                r_drain <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode             <= s_axis_tuser;
            r_in_flags.fin_flag     <= s_axis_tdata[0];
            r_in_flags.fin_ack_flag <= s_axis_tdata[1];
            r_in_flags.reset_flag   <= s_axis_tdata[2];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ctf_pkg::OUT_DATA_W - ctf_pkg::RESULT_W){1'b0}}, r_out};

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for connection_teardown_fsm
// drives close-handshake events and config writes, predicts each result
// in a scoreboard class; depends on ctf_pkg and connection_teardown_fsm
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode the block does not define, must be rejected
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // flag sets of a received message
    localparam ctf_pkg::t_flags FL_NONE = 3'b000;
    localparam ctf_pkg::t_flags FL_FIN  = 3'b001;
    localparam ctf_pkg::t_flags FL_ACK  = 3'b010;
    localparam ctf_pkg::t_flags FL_RST  = 3'b100;
    localparam ctf_pkg::t_flags FL_ALL  = 3'b111;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int WAIT_MAX       = 10;
    localparam int PIPE_DRAIN     = 8;     // drain margin after the last result
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_EVENTS   = 108;
    localparam int REPORT_MAX     = 40;

    // scoreboard: tracks the connection state, predicts and checks results
    class teardown_scoreboard;
        logic [2:0]       conn_code;
        logic             drain;
        ctf_pkg::t_result pending_q[$];
        int               mismatches;
        int               events;
        int               checked;
        int               rejected;
        logic [7:0]       states_seen;
        logic [1:0]       fin_prio_seen;

        function new();
            conn_code     = ctf_pkg::CODE_CLOSED;
            drain         = 1'b0;
            mismatches    = 0;
            events        = 0;
            checked       = 0;
            rejected      = 0;
            states_seen   = '0;
            fin_prio_seen = '0;
        endfunction

        // own FIN goes out, fin_wait1 from ready, last_ack otherwise
        function void send_own_fin(ref ctf_pkg::t_result r, ref logic [2:0] st);
            r.send_fin         = 1'b1;
            r.fin_low_priority = drain;
            r.notify           = ctf_pkg::NOTE_CLOSED;
            st = (st == ctf_pkg::CODE_READY) ? ctf_pkg::CODE_FIN_WAIT1
                                             : ctf_pkg::CODE_LAST_ACK;
        endfunction

        function ctf_pkg::t_result teardown_step(logic [1:0] op, ctf_pkg::t_flags fl);
            ctf_pkg::t_result r;
            logic [2:0]       st;
            r  = '0;
            st = conn_code;
            case (op)
                ctf_pkg::OP_RECEIVE: begin
                    // first receive opens the connection
                    if (st == ctf_pkg::CODE_CLOSED) begin
                        r.notify = ctf_pkg::NOTE_NEW;
                        st = ctf_pkg::CODE_READY;
                    end
                    if (st == ctf_pkg::CODE_TIME_WAIT) begin
                        r.send_reset = 1'b1;
                    end else if (fl.reset_flag) begin
                        r.notify      = ctf_pkg::NOTE_BROKEN;
                        r.release_res = 1'b1;
                        st = ctf_pkg::CODE_CLOSED;
                    end else if (fl.fin_flag) begin
                        r.send_fin_ack = 1'b1;
                        case (st)
                            ctf_pkg::CODE_READY: begin
                                // passes close_wait, answers with own fin at once
                                st = ctf_pkg::CODE_CLOSE_WAIT;
                                send_own_fin(r, st);
                            end
                            ctf_pkg::CODE_FIN_WAIT1: st = ctf_pkg::CODE_CLOSING;
                            ctf_pkg::CODE_FIN_WAIT2: begin
                                st = ctf_pkg::CODE_TIME_WAIT;
                                r.start_wait_timer = 1'b1;
                            end
                            default: r.bad_event = 1'b1;
                        endcase
                    end else if (fl.fin_ack_flag) begin
                        case (st)
                            ctf_pkg::CODE_LAST_ACK: begin
                                st = ctf_pkg::CODE_CLOSED;
                                r.release_res = 1'b1;
                            end
                            ctf_pkg::CODE_FIN_WAIT1: st = ctf_pkg::CODE_FIN_WAIT2;
                            ctf_pkg::CODE_CLOSING: begin
                                st = ctf_pkg::CODE_TIME_WAIT;
                                r.start_wait_timer = 1'b1;
                            end
                            default: r.bad_event = 1'b1;
                        endcase
                    end
                end
                ctf_pkg::OP_CLOSE: begin
                    if (st == ctf_pkg::CODE_READY || st == ctf_pkg::CODE_CLOSE_WAIT)
                        send_own_fin(r, st);
                    else
                        r.bad_event = 1'b1;
                end
                ctf_pkg::OP_TIMER: begin
                    if (st == ctf_pkg::CODE_TIME_WAIT) begin
                        st = ctf_pkg::CODE_CLOSED;
                        r.release_res = 1'b1;
                    end else begin
                        r.bad_event = 1'b1;
                    end
                end
                default: r.bad_event = 1'b1;
            endcase
            conn_code    = st;
            r.next_state = st;
            r.may_send   = (st == ctf_pkg::CODE_CLOSED || st == ctf_pkg::CODE_READY);
            return r;
        endfunction

        function void note_event(logic [1:0] op, ctf_pkg::t_flags fl);
            ctf_pkg::t_result r;
            r = teardown_step(op, fl);
            events++;
            if (r.bad_event)
                rejected++;
            states_seen[r.next_state] = 1'b1;
            if (r.send_fin)
                fin_prio_seen[r.fin_low_priority] = 1'b1;
            pending_q = {pending_q, r};
        endfunction

        task report_mismatch(string msg);
            // keep the log short on a badly broken block
            if (mismatches < REPORT_MAX)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [2:0] got, logic [2:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                    checked, name, got, want));
        endtask

        task check_result(ctf_pkg::t_result got);
            ctf_pkg::t_result want;
            checked++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived unexpected (%h)",
                    checked, got));
                return;
            end
            want = pending_q.pop_front();
            compare_field("next_state", got.next_state, want.next_state);
            compare_field("send_fin_ack", {2'b0, got.send_fin_ack},
                {2'b0, want.send_fin_ack});
            compare_field("send_fin", {2'b0, got.send_fin}, {2'b0, want.send_fin});
            compare_field("fin_low_priority", {2'b0, got.fin_low_priority},
                {2'b0, want.fin_low_priority});
            compare_field("send_reset", {2'b0, got.send_reset},
                {2'b0, want.send_reset});
            compare_field("start_wait_timer", {2'b0, got.start_wait_timer},
                {2'b0, want.start_wait_timer});
            compare_field("release_res", {2'b0, got.release_res},
                {2'b0, want.release_res});
            compare_field("notify", {1'b0, got.notify}, {1'b0, want.notify});
            compare_field("bad_event", {2'b0, got.bad_event}, {2'b0, want.bad_event});
            compare_field("may_send", {2'b0, got.may_send}, {2'b0, want.may_send});
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic                           i_cfg_data = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;    // [0] fin, [1] fin_ack, [2] rst
    logic [1:0]                     s_axis_tuser = '0;    // [1:0] opcode
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [ctf_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // t_result from bit 0 up

    teardown_scoreboard sb;
    bit  steady = 1'b0;      // stretch with no idling on either side
    int  out_hold = 0;       // cycles the result side still stalls
    int  stuck_cycles = 0;
    int  cfg_writes = 0;

    connection_teardown_fsm DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // result side: tready follows the stall count, changed at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= (out_hold == 0);
    end

    // result side: sample at the rising edge, check, draw the next stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(ctf_pkg::t_result'(m_axis_tdata[ctf_pkg::RESULT_W-1:0]));
                out_hold = draw_wait();
            end else if (out_hold > 0) begin
                out_hold--;
            end
        end
    end

    // watchdog: cycles in a row with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one event transaction: optional gap, then hold tvalid until accepted
    task automatic send_event(logic [1:0] op, ctf_pkg::t_flags fl);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, fl};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_event(op, fl);
    endtask

    // stop the event stream and let every result come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_drain(logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.drain = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly events the current state accepts, so teardowns run to the end;
    // the rest is noise over every opcode and flag combination
    task automatic pick_event(output logic [1:0] op, output ctf_pkg::t_flags fl);
        logic [2:0] raw;
        raw = 3'($urandom_range(0, 7));
        op  = ctf_pkg::OP_RECEIVE;
        fl  = FL_NONE;
        if ($urandom_range(0, 99) < 15) begin
            op = 2'($urandom_range(0, 3));
            fl = raw;
        end else begin
            case (sb.conn_code)
                ctf_pkg::CODE_CLOSED:    fl = raw & 3'b011;
                ctf_pkg::CODE_READY: begin
                    case ($urandom_range(0, 2))
                        0:       op = ctf_pkg::OP_CLOSE;
                        1:       fl = FL_FIN;
                        default: fl = FL_NONE;
                    endcase
                end
                ctf_pkg::CODE_FIN_WAIT1: fl = 3'($urandom_range(1, 3));
                ctf_pkg::CODE_FIN_WAIT2: fl = FL_FIN | (raw & FL_ACK);
                ctf_pkg::CODE_CLOSING:   fl = FL_ACK;
                ctf_pkg::CODE_TIME_WAIT: begin
                    if ($urandom_range(0, 3) == 0)
                        fl = raw;
                    else
                        op = ctf_pkg::OP_TIMER;
                end
                ctf_pkg::CODE_CLOSE_WAIT: op = ctf_pkg::OP_CLOSE;
                default:                  fl = FL_ACK;     // last_ack
            endcase
            // an occasional reset from the peer breaks the connection
            if (op == ctf_pkg::OP_RECEIVE && $urandom_range(0, 99) < 6)
                fl.reset_flag = 1'b1;
        end
    endtask

    initial begin
        logic [1:0]      op;
        ctf_pkg::t_flags fl;

        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk, low-priority fin
        write_drain(1'b1);
        send_event(ctf_pkg::OP_TIMER, FL_NONE);       // stray timer in closed
        send_event(ctf_pkg::OP_CLOSE, FL_ALL);        // close refused in closed
        send_event(OP_UNUSED, FL_NONE);               // unused opcode
        send_event(ctf_pkg::OP_RECEIVE, FL_NONE);     // first receive, new connection
        send_event(ctf_pkg::OP_RECEIVE, FL_ACK);      // fin-ack not allowed in ready
        send_event(OP_UNUSED, FL_ALL);
        send_event(ctf_pkg::OP_CLOSE, FL_NONE);       // active close to fin_wait1
        send_event(ctf_pkg::OP_RECEIVE, FL_ACK);      // fin_wait2
        send_event(ctf_pkg::OP_RECEIVE, FL_ACK);      // fin-ack not allowed in fin_wait2
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // time_wait, timer armed
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // reset answered in time_wait
        send_event(ctf_pkg::OP_RECEIVE, FL_RST);      // rst ignored in time_wait
        send_event(ctf_pkg::OP_CLOSE, FL_NONE);       // close refused in time_wait
        send_event(ctf_pkg::OP_TIMER, FL_NONE);       // expiry releases
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // first receive with fin, last_ack
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // fin not allowed in last_ack
        send_event(ctf_pkg::OP_RECEIVE, FL_ACK);      // passive close done
        send_event(ctf_pkg::OP_RECEIVE, FL_ALL);      // first receive with rst, broken
        send_event(ctf_pkg::OP_RECEIVE, FL_NONE);
        send_event(ctf_pkg::OP_CLOSE, FL_NONE);
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // simultaneous close, closing
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);      // fin not allowed in closing
        send_event(ctf_pkg::OP_RECEIVE, FL_ACK);      // time_wait
        send_event(ctf_pkg::OP_TIMER, FL_NONE);
        wait_idle();

        // high-priority fin, then random phases alternating the setting
        write_drain(1'b0);
        send_event(ctf_pkg::OP_RECEIVE, FL_FIN);
        send_event(ctf_pkg::OP_RECEIVE, FL_RST);      // rst in last_ack breaks it
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_drain(ph[0]);
            end
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                pick_event(op, fl);
                send_event(op, fl);
            end
        end

        wait_idle();
        $display("covered %0d events (%0d rejected), %0d results, %0d config writes",
            sb.events, sb.rejected, sb.checked, cfg_writes);
        $display("states reached %b, fin priorities used %b",
            sb.states_seen, sb.fin_prio_seen);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ctf_pkg.sv
hw/rtl/ctf_next_logic.sv
hw/rtl/connection_teardown_fsm.sv
bench/testbench.sv
